// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the hasher RTL.
// Depends on clk_i and rst_ni being present in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("hasher assertion failed");

// Check on every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("hasher assertion failed");

`endif

// ----- rtl/core/sha1bh_pkg.sv -----
// Types, constants and round functions of the SHA-1 byte stream hasher.
// No dependencies; imported by the compression unit and the top level.
package sha1bh_pkg;

  typedef logic [31:0] word_t;
  typedef logic [4:0][31:0] chain_t;
  typedef logic [0:15][31:0] block_t;

  typedef struct packed {
    logic start;
    logic clear;
  } ctl_t;

  localparam int unsigned RndW = 7;
  localparam logic [RndW-1:0] RoundLast = 7'd79;
  localparam logic [RndW-1:0] RoundFinal = 7'd80;

  localparam chain_t ChainInit = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  localparam word_t K0 = 32'h5A827999;
  localparam word_t K1 = 32'h6ED9EBA1;
  localparam word_t K2 = 32'h8F1BBCDC;
  localparam word_t K3 = 32'hCA62C1D6;

  localparam logic [7:0] PadMark = 8'h80;
  localparam logic [5:0] LenOffset = 6'd56;

  function automatic word_t round_f(logic [RndW-1:0] t, word_t b, word_t c, word_t d);
    word_t f;
    if (t < 7'd20) begin
      f = ((c ^ d) & b) ^ d;
    end else if (t < 7'd40) begin
      f = b ^ c ^ d;
    end else if (t < 7'd60) begin
      f = (b & c) | (d & (b | c));
    end else begin
      f = b ^ c ^ d;
    end
    return f;
  endfunction

  function automatic word_t round_k(logic [RndW-1:0] t);
    word_t k;
    if (t < 7'd20) begin
      k = K0;
    end else if (t < 7'd40) begin
      k = K1;
    end else if (t < 7'd60) begin
      k = K2;
    end else begin
      k = K3;
    end
    return k;
  endfunction

endpackage

// ----- rtl/core/sha1bh_compress.sv -----
// SHA-1 compression unit: one round per cycle over a 16-word rolling schedule.
// Holds the chaining words. Depends on sha1bh_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sha1bh_compress (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sha1bh_pkg::ctl_t    ctl_i,
  input  sha1bh_pkg::block_t  block_i,
  output sha1bh_pkg::chain_t  chain_o,
  output logic                busy_o
);
  import sha1bh_pkg::*;

  chain_t          chain_q, chain_d;
  word_t           a_q, b_q, c_q, d_q, e_q;
  word_t           a_d, b_d, c_d, d_d, e_d;
  block_t          sched_q, sched_d;
  logic [RndW-1:0] rnd_q, rnd_d;
  logic            busy_q, busy_d;
  word_t           w_new;
  word_t           w_mix;
  word_t           tmp;

  assign w_mix = sched_q[13] ^ sched_q[8] ^ sched_q[2] ^ sched_q[0];
  assign w_new = {w_mix[30:0], w_mix[31]};
  assign tmp   = {a_q[26:0], a_q[31:27]} + round_f(rnd_q, b_q, c_q, d_q) + e_q
               + sched_q[0] + round_k(rnd_q);

  always_comb begin
    chain_d = chain_q;
    a_d     = a_q;
    b_d     = b_q;
    c_d     = c_q;
    d_d     = d_q;
    e_d     = e_q;
    sched_d = sched_q;
    rnd_d   = rnd_q;
    busy_d  = busy_q;
    if (ctl_i.clear) begin
      chain_d = ChainInit;
    end
    if (ctl_i.start) begin
      a_d     = chain_q[0];
      b_d     = chain_q[1];
      c_d     = chain_q[2];
      d_d     = chain_q[3];
      e_d     = chain_q[4];
      sched_d = block_i;
      rnd_d   = '0;
      busy_d  = 1'b1;
    end else if (busy_q) begin
      if (rnd_q == RoundFinal) begin
        chain_d[0] = chain_q[0] + a_q;
        chain_d[1] = chain_q[1] + b_q;
        chain_d[2] = chain_q[2] + c_q;
        chain_d[3] = chain_q[3] + d_q;
        chain_d[4] = chain_q[4] + e_q;
        busy_d     = 1'b0;
      end else begin
        a_d     = tmp;
        b_d     = a_q;
        c_d     = {b_q[1:0], b_q[31:2]};
        d_d     = c_q;
        e_d     = d_q;
        sched_d = {sched_q[1:15], w_new};
        rnd_d   = rnd_q + 7'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q <= ChainInit;
      rnd_q   <= '0;
      busy_q  <= 1'b0;
    end else begin
      chain_q <= chain_d;
      rnd_q   <= rnd_d;
      busy_q  <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q     <= a_d;
    b_q     <= b_d;
    c_q     <= c_d;
    d_q     <= d_d;
    e_q     <= e_d;
    sched_q <= sched_d;
  end

  assign chain_o = chain_q;
  assign busy_o  = busy_q;

  `ASSERT_CLK(a_rnd_range, (busy_q |-> (rnd_q <= RoundFinal)))
  `ASSERT_CLK(a_start_idle, (ctl_i.start |-> !busy_q))
  `ASSERT_CLK(a_clear_idle, (ctl_i.clear |-> !busy_q))
  `ASSERT_CLK(a_final_ends, ((busy_q && rnd_q == RoundFinal) |=> !busy_q))
  `ASSERT_CLK(a_last_round, ((busy_q && rnd_q == RoundLast) |=> (busy_q && rnd_q == RoundFinal)))

endmodule

// ----- rtl/core/sha1_byte_stream_hasher_core.sv -----
// SHA-1 byte stream hasher top level: byte packing, padding sequencer, digest output.
// Depends on sha1bh_pkg, sha1bh_compress and assert_macros.svh.
//
// Input stream: one message byte per beat on s_axis_tdata_i, qualified by
// s_axis_tuser_i; s_axis_tlast_i ends the message after the byte of that beat
// (a beat with tlast and tuser low ends the message without a byte).
// Output stream: one 160-bit digest beat per message, word 0 in the low bits.
// Timing: byte beats are taken one per cycle while s_axis_tready_o is high; every 64th
// message byte starts the compression unit (80 rounds, one per cycle, then a step that
// adds into the chaining words and one that hands back to the sequencer). A last beat
// is followed by 9 to 72 padding bytes, one per cycle, and one or two compression runs;
// the digest then enters the output register from ST_EMIT once that register is free.
// The sustained byte rate is set by the single shared round unit.
// s_axis_tready_o is low while padding or compressing, and while a finished
// digest waits for a stalled receiver in front of a full output register.
// Reset clears the message, loads the initial chaining words and empties the output
// register; each digest clears the message and reloads the chaining words too.
`include "assert_macros.svh"

module sha1_byte_stream_hasher_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [7:0]   s_axis_tdata_i,   // [7:0] data_byte
  input  logic         s_axis_tuser_i,   // [0] byte_valid
  input  logic         s_axis_tlast_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [159:0] m_axis_tdata_o    // digest_word0 .. digest_word4, 32 bits each
);
  import sha1bh_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PAD  = 2'd1;
  localparam logic [1:0] ST_COMP = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  localparam logic [1:0] PAD_MARK = 2'd0;
  localparam logic [1:0] PAD_ZERO = 2'd1;
  localparam logic [1:0] PAD_LEN  = 2'd2;

  logic [1:0]   state_q, state_d;
  logic [1:0]   stage_q, stage_d;
  logic         pad_q, pad_d;
  logic [5:0]   cnt_q, cnt_d, cnt_inc;
  logic [63:0]  bitcnt_q, bitcnt_d;
  logic [511:0] blk_q, blk_d;
  logic         out_valid_q, out_valid_d;
  chain_t       out_q;
  chain_t       chain;
  logic         busy;
  ctl_t         ctl;
  logic         accept;
  logic         absorb;
  logic [7:0]   abs_byte;
  logic         emit_go;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept  = s_axis_tvalid_i && s_axis_tready_o;
  assign cnt_inc = cnt_q + 6'd1;
  assign emit_go = (state_q == ST_EMIT) && (!out_valid_q || m_axis_tready_i);

  always_comb begin
    state_d  = state_q;
    stage_d  = stage_q;
    pad_d    = pad_q;
    bitcnt_d = bitcnt_q;
    absorb   = 1'b0;
    abs_byte = '0;
    ctl      = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (s_axis_tuser_i) begin
            absorb   = 1'b1;
            abs_byte = s_axis_tdata_i;
            bitcnt_d = bitcnt_q + 64'd8;
          end
          if (s_axis_tlast_i) begin
            pad_d   = 1'b1;
            stage_d = PAD_MARK;
          end
          if (s_axis_tuser_i && (&cnt_q)) begin
            state_d = ST_COMP;
          end else if (s_axis_tlast_i) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        absorb = 1'b1;
        unique case (stage_q)
          PAD_MARK: abs_byte = PadMark;
          PAD_LEN:  abs_byte = bitcnt_q[63:56];
          default:  abs_byte = '0;
        endcase
        if (stage_q == PAD_LEN) begin
          bitcnt_d = {bitcnt_q[55:0], 8'd0};
        end else begin
          stage_d = (cnt_inc == LenOffset) ? PAD_LEN : PAD_ZERO;
        end
        if (&cnt_q) begin
          state_d = ST_COMP;
        end
      end
      ST_COMP: begin
        if (!busy) begin
          if (!pad_q) begin
            state_d = ST_IDLE;
          end else if (stage_q == PAD_LEN) begin
            state_d = ST_EMIT;
          end else begin
            state_d = ST_PAD;
          end
        end
      end
      ST_EMIT: begin
        if (emit_go) begin
          ctl.clear = 1'b1;
          bitcnt_d  = '0;
          pad_d     = 1'b0;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    ctl.start = absorb && (&cnt_q);
  end

  assign cnt_d = absorb ? cnt_inc : cnt_q;
  assign blk_d = absorb ? {blk_q[503:0], abs_byte} : blk_q;
  assign out_valid_d = emit_go ? 1'b1 : (m_axis_tready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      stage_q     <= PAD_MARK;
      pad_q       <= 1'b0;
      cnt_q       <= '0;
      bitcnt_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      stage_q     <= stage_d;
      pad_q       <= pad_d;
      cnt_q       <= cnt_d;
      bitcnt_q    <= bitcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    blk_q <= blk_d;
    if (emit_go) begin
      out_q <= chain;
    end
  end

  sha1bh_compress u_compress (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl),
    .block_i (block_t'(blk_d)),
    .chain_o (chain),
    .busy_o  (busy)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q;

  `ASSERT_CLK(a_busy_in_comp, (busy |-> (state_q == ST_COMP)))
  `ASSERT_CLK(a_ready_not_busy, (s_axis_tready_o |-> !busy))
  `ASSERT_CLK(a_emit_loads, (emit_go |=> m_axis_tvalid_o))
  `ASSERT_CLK(a_emit_clears, (emit_go |=> (bitcnt_q == 64'd0 && cnt_q == 6'd0 && !pad_q)))
  `ASSERT_CLK(a_emit_on_boundary, ((state_q == ST_EMIT) |-> (cnt_q == 6'd0 && pad_q)))

endmodule

// ----- tb/sha1_byte_stream_hasher_core_tb.sv -----
// Self-checking testbench for sha1_byte_stream_hasher_core: byte beats in, digest beats out.
// Predicts every digest with its own SHA-1 byte hasher and checks each output beat word by word.
// Depends on sha1bh_pkg and the hasher RTL.
module sha1_byte_stream_hasher_core_tb;
  import sha1bh_pkg::word_t;
  import sha1bh_pkg::chain_t;
  import sha1bh_pkg::ChainInit;
  import sha1bh_pkg::PadMark;
  import sha1bh_pkg::LenOffset;

  localparam int CycleLimit = 1000000;
  localparam int DrainCycles = 300;
  localparam int PhaseBytes = 667;

  typedef struct packed {
    logic [7:0] data;
    logic       byte_valid;
    logic       eom;
  } byte_beat_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [7:0]   s_tdata = 8'h00;
  logic         s_tuser = 1'b0;
  logic         s_tlast = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [159:0] m_tdata;

  byte_beat_t   beat_q[$];
  byte_beat_t   beat_on_bus;
  chain_t       digest_q[$];
  int           send_idle_pct = 31;
  int           recv_idle_pct = 87;
  int           error_count = 0;
  int           cycle_count = 0;

  chain_t       hash_state = ChainInit;
  word_t        msg_block[16];
  logic [5:0]   block_fill = '0;
  logic [63:0]  msg_bits = '0;

  sha1_byte_stream_hasher_core uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  always #5 clk_i = ~clk_i;

  function automatic void clear_hasher();
    hash_state = ChainInit;
    for (int i = 0; i < 16; i++) begin
      msg_block[i] = '0;
    end
    block_fill = '0;
    msg_bits = '0;
  endfunction

  function automatic void compress_block();
    word_t sched[16];
    word_t a, b, c, d, e, f, k, wt, tmp;
    for (int i = 0; i < 16; i++) begin
      sched[i] = msg_block[i];
    end
    a = hash_state[0];
    b = hash_state[1];
    c = hash_state[2];
    d = hash_state[3];
    e = hash_state[4];
    for (int t = 0; t < 80; t++) begin
      if (t < 16) begin
        wt = sched[t];
      end else begin
        wt = sched[(t - 3) % 16] ^ sched[(t - 8) % 16] ^ sched[(t - 14) % 16] ^ sched[t % 16];
        wt = {wt[30:0], wt[31]};
        sched[t % 16] = wt;
      end
      if (t < 20) begin
        f = (b & c) | (~b & d);
        k = 32'h5A827999;
      end else if (t < 40) begin
        f = b ^ c ^ d;
        k = 32'h6ED9EBA1;
      end else if (t < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = 32'h8F1BBCDC;
      end else begin
        f = b ^ c ^ d;
        k = 32'hCA62C1D6;
      end
      tmp = {a[26:0], a[31:27]} + f + e + wt + k;
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = tmp;
    end
    hash_state[0] = hash_state[0] + a;
    hash_state[1] = hash_state[1] + b;
    hash_state[2] = hash_state[2] + c;
    hash_state[3] = hash_state[3] + d;
    hash_state[4] = hash_state[4] + e;
  endfunction

  function automatic void pack_byte(logic [7:0] value);
    logic [3:0] idx;
    idx = block_fill[5:2];
    msg_block[idx] = {msg_block[idx][23:0], value};
    block_fill = block_fill + 6'd1;
    if (block_fill == 6'd0) begin
      compress_block();
    end
  endfunction

  function automatic void hash_beat(byte_beat_t beat);
    logic [63:0] len;
    if (beat.byte_valid) begin
      pack_byte(beat.data);
      msg_bits = msg_bits + 64'd8;
    end
    if (beat.eom) begin
      len = msg_bits;
      pack_byte(PadMark);
      while (block_fill != LenOffset) begin
        pack_byte(8'h00);
      end
      for (int i = 7; i >= 0; i--) begin
        pack_byte(len[8*i +: 8]);
      end
      digest_q.push_back(hash_state);
      clear_hasher();
    end
  endfunction

  task automatic report_mismatch(string what);
    $display("MISMATCH at cycle %0d: %s", cycle_count, what);
    error_count++;
  endtask

  task automatic add_beat(logic [7:0] data, logic byte_valid, logic eom);
    byte_beat_t beat;
    beat.data = data;
    beat.byte_valid = byte_valid;
    beat.eom = eom;
    beat_q.push_back(beat);
  endtask

  task automatic add_message(int len);
    logic end_on_byte;
    end_on_byte = (len > 0) && ($urandom_range(1) == 1);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(15) == 0) begin
        add_beat(8'($urandom), 1'b0, 1'b0);
      end
      add_beat(8'($urandom), 1'b1, end_on_byte && (i == len - 1));
    end
    if (!end_on_byte) begin
      add_beat(8'($urandom), 1'b0, 1'b1);
    end
  endtask

  function automatic int pick_length();
    int sel;
    int edge_lens[10] = '{0, 1, 55, 56, 63, 64, 65, 119, 120, 128};
    sel = $urandom_range(9);
    if (sel < 6) begin
      return $urandom_range(20);
    end else if (sel < 8) begin
      return edge_lens[$urandom_range(9)];
    end
    return $urandom_range(200);
  endfunction

  task automatic wait_idle();
    while (beat_q.size() != 0 || s_tvalid || digest_q.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Driver: predict on acceptance, then offer the next beat or idle.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_tvalid && s_tready) begin
        hash_beat(beat_on_bus);
      end
      if (!s_tvalid || s_tready) begin
        if (beat_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          beat_on_bus = beat_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= beat_on_bus.data;
          s_tuser  <= beat_on_bus.byte_valid;
          s_tlast  <= beat_on_bus.eom;
        end else begin
          s_tvalid <= 1'b0;
          s_tdata  <= 8'($urandom);
          s_tuser  <= 1'($urandom);
          s_tlast  <= 1'($urandom);
        end
      end
    end
  end

  // Monitor: check each digest beat against the oldest prediction.
  always @(posedge clk_i) begin
    chain_t want;
    if (rst_ni) begin
      if (m_tvalid && m_tready) begin
        if (digest_q.size() == 0) begin
          report_mismatch($sformatf("unexpected digest %h", m_tdata));
        end else begin
          want = digest_q.pop_front();
          for (int i = 0; i < 5; i++) begin
            if (m_tdata[32*i +: 32] !== want[i]) begin
              report_mismatch($sformatf("digest_word%0d got %h want %h",
                                        i, m_tdata[32*i +: 32], want[i]));
            end
          end
        end
      end
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int count;
    int len;
    clear_hasher();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty message, "abc", single extreme bytes, no-op beats mid-message
    add_beat(8'hA5, 1'b0, 1'b0);
    add_beat(8'hFF, 1'b0, 1'b1);
    add_beat(8'h61, 1'b1, 1'b0);
    add_beat(8'h62, 1'b1, 1'b0);
    add_beat(8'h63, 1'b1, 1'b1);
    add_beat(8'h00, 1'b1, 1'b1);
    add_beat(8'hFF, 1'b1, 1'b1);
    add_beat(8'h5A, 1'b0, 1'b0);
    add_beat(8'h5A, 1'b1, 1'b0);
    add_beat(8'h00, 1'b0, 1'b0);
    add_beat(8'h00, 1'b0, 1'b1);
    add_beat(8'h61, 1'b1, 1'b0);
    add_beat(8'h62, 1'b1, 1'b0);
    add_beat(8'h00, 1'b0, 1'b1);

    for (int phase = 0; phase < 3; phase++) begin
      wait_idle();
      send_idle_pct = (phase == 0) ? 31 : (phase == 1) ? 87 : 0;
      recv_idle_pct = (phase == 0) ? 87 : (phase == 1) ? 31 : 0;
      count = 0;
      while (count < PhaseBytes) begin
        len = pick_length();
        add_message(len);
        count += len + 1;
      end
    end

    wait_idle();
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/sha1bh_pkg.sv
rtl/core/sha1bh_compress.sv
rtl/core/sha1_byte_stream_hasher_core.sv
tb/sha1_byte_stream_hasher_core_tb.sv
